>>> sv/char_histogram_l1_ranker_defines.svh
// Assertion macros shared by the character histogram ranker modules.
`ifndef CHAR_HISTOGRAM_L1_RANKER_DEFINES_SVH
`define CHAR_HISTOGRAM_L1_RANKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CHL1_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("chl1 assertion failed");

// Next-cycle implication, checked outside reset.
`define CHL1_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("chl1 assertion failed");

`endif

>>> sv/chl1_pkg.sv
// Package with codes, states and helpers for the character histogram ranker.
package chl1_pkg;

    localparam int BIN_BITS      = 8;
    localparam int ENTRY_BITS    = 4;
    localparam int DIST_OUT_BITS = 21;
    localparam int MAX_ENTRIES   = 16;

    typedef enum logic [1:0] {
        K_LOAD  = 2'd0,
        K_QUERY = 2'd1,
        K_ERASE = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_RANKED      = 3'd0,
        ST_LOAD_OK     = 3'd1,
        ST_LOAD_REJ    = 3'd2,
        ST_ERASED      = 3'd3,
        ST_ERASE_EMPTY = 3'd4,
        ST_NO_ENTRIES  = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_BUMP,
        S_ERASE,
        S_RES,
        S_WALK,
        S_DRAIN,
        S_INS,
        S_QCLR,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic ins;
        logic pop;
    } t_rank_ctl;

    // Upper-case ASCII letters map to lower case; every other byte is kept.
    function automatic logic [BIN_BITS-1:0] fold_byte(input logic [BIN_BITS-1:0] b);
        logic [BIN_BITS-1:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

>>> sv/chl1_acc.sv
// Shared absolute-difference accumulator used for every bin of the distance walk.
module chl1_acc #(
    parameter int CW = 12,
    parameter int DW = 20
) (
    input  logic          i_clk,
    input  logic          i_clr,
    input  logic          i_en,
    input  logic [CW-1:0] i_ref,
    input  logic [CW-1:0] i_qry,
    output logic [DW-1:0] o_sum
);

    logic [DW-1:0] r_sum;
    logic [CW-1:0] diff;

    assign diff  = (i_ref > i_qry) ? (i_ref - i_qry) : (i_qry - i_ref);
    assign o_sum = r_sum;

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_sum <= '0;
        end else if (i_en) begin
            r_sum <= r_sum + DW'(diff);
        end
    end

endmodule

>>> sv/chl1_rank.sv
// Sorted list of entry distances: ascending insert with stable ties, popped from the head.
`include "char_histogram_l1_ranker_defines.svh"

module chl1_rank #(
    parameter int NE   = 16,
    parameter int DW   = 20,
    parameter int CNTW = 5
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  chl1_pkg::t_rank_ctl                  i_ctl,
    input  logic [chl1_pkg::ENTRY_BITS-1:0]      i_idx,
    input  logic [DW-1:0]                        i_dist,
    output logic [chl1_pkg::ENTRY_BITS-1:0]      o_head_idx,
    output logic [DW-1:0]                        o_head_dist,
    output logic [CNTW-1:0]                      o_count
);

    logic [DW-1:0]                   r_d [NE];
    logic [chl1_pkg::ENTRY_BITS-1:0] r_i [NE];
    logic [CNTW-1:0]                 r_cnt;
    logic [DW-1:0]                   n_d [NE];
    logic [chl1_pkg::ENTRY_BITS-1:0] n_i [NE];
    logic [NE-1:0]                   gt;
    logic [NE-1:0]                   prev_gt;
    logic [DW-1:0]                   prev_d [NE];
    logic [chl1_pkg::ENTRY_BITS-1:0] prev_i [NE];

    always_comb begin
        for (int i = 0; i < NE; i++) begin
            gt[i] = (CNTW'(i) >= r_cnt) || (r_d[i] > i_dist);
        end
        prev_gt[0] = 1'b0;
        prev_d[0]  = r_d[0];
        prev_i[0]  = r_i[0];
        for (int i = 1; i < NE; i++) begin
            prev_gt[i] = gt[i-1];
            prev_d[i]  = r_d[i-1];
            prev_i[i]  = r_i[i-1];
        end
        for (int i = 0; i < NE; i++) begin
            n_d[i] = r_d[i];
            n_i[i] = r_i[i];
            if (i_ctl.ins) begin
                // Larger entries move one place down; the new one fills the first gap.
                if (gt[i] && !prev_gt[i]) begin
                    n_d[i] = i_dist;
                    n_i[i] = i_idx;
                end else if (gt[i]) begin
                    n_d[i] = prev_d[i];
                    n_i[i] = prev_i[i];
                end
            end else if (i_ctl.pop && i < NE - 1) begin
                n_d[i] = r_d[(i < NE - 1) ? i + 1 : i];
                n_i[i] = r_i[(i < NE - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NE; i++) begin
            r_d[i] <= n_d[i];
            r_i[i] <= n_i[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.clear) begin
            r_cnt <= '0;
        end else if (i_ctl.ins) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (i_ctl.pop) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_head_idx  = r_i[0];
    assign o_head_dist = r_d[0];
    assign o_count     = r_cnt;

    `CHL1_ASSERT_IMPL(a_cnt_bound, 1'b1, r_cnt <= CNTW'(NE))
    `CHL1_ASSERT_IMPL(a_no_pop_empty, i_ctl.pop, r_cnt != '0)
    `CHL1_ASSERT_NEXT(a_ins_grows, i_ctl.ins && !i_ctl.clear, r_cnt == $past(r_cnt) + 1'b1)

endmodule

>>> sv/char_histogram_l1_ranker.sv
// Top level of the character histogram L1 ranker: sequencer, histogram memories, result register.
// After reset the block clears its NE*256 reference bins (at most 4096) and the query bins with o_stall
// high. A counted load or query character is a read-modify-write of one bin through the memory port;
// a final load beat also presents its result. An erase in range sweeps the entry's 256 bins
// before it presents its result. A final query character walks every valid entry through the single
// shared abs-difference accumulator, then clears the query histogram and emits one result per cycle
// while the output is taken, or a single no-entries result when no entry is valid.
// Only one item is in work at a time; results leave through a one-beat output register.
`include "char_histogram_l1_ranker_defines.svh"

module char_histogram_l1_ranker #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_entry,
    input  logic [7:0]  i_char_byte,
    input  logic        i_has_char,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [3:0]  o_entry_index,
    output logic [20:0] o_distance,
    output logic        o_final_res
);

    localparam int NE    = (ENTRIES < chl1_pkg::MAX_ENTRIES) ? ENTRIES : chl1_pkg::MAX_ENTRIES;
    localparam int EIW   = (NE > 1) ? $clog2(NE) : 1;
    localparam int DEPTH = NE * 256;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = COUNT_BITS + 8;
    localparam int CNTW  = $clog2(NE + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    chl1_pkg::t_state r_state, n_state;

    logic [1:0]      r_kind;
    logic [3:0]      r_entry;
    logic [7:0]      r_ch;
    logic            r_last;
    logic [EIW-1:0]  r_e;
    logic [7:0]      r_b;
    logic [AW-1:0]   r_init;
    logic [NE-1:0]   r_pres;
    logic            r_rdv;
    logic [2:0]      r_rs;
    logic [3:0]      r_ri;

    logic [COUNT_BITS-1:0] ref_mem [DEPTH];
    logic [COUNT_BITS-1:0] q_mem [256];
    logic [COUNT_BITS-1:0] r_ref_rd, r_q_rd;

    logic [7:0]      in_ch;
    logic            in_inr, in_open, accept, slot_free;
    logic            e_last, skip_e, emit_done;
    logic [AW-1:0]   ref_raddr, ref_waddr;
    logic [7:0]      q_raddr, q_waddr;
    logic            ref_we, q_we;
    logic [COUNT_BITS-1:0] ref_wdata, q_wdata;
    logic            acc_clr, acc_en;
    logic [DW-1:0]   acc_sum;
    chl1_pkg::t_rank_ctl rank_ctl;
    logic [3:0]      head_idx;
    logic [DW-1:0]   head_dist;
    logic [CNTW-1:0] rank_cnt;
    logic            out_load;
    logic [2:0]      out_status;
    logic [3:0]      out_idx;
    logic [20:0]     out_dist;
    logic            out_fin;
    logic            set_pres, clr_pres;

    assign in_ch     = chl1_pkg::fold_byte(i_char_byte);
    assign in_inr    = {1'b0, i_entry} < 5'(NE);
    assign in_open   = in_inr && !r_pres[i_entry[EIW-1:0]];
    assign accept    = (r_state == chl1_pkg::S_IDLE) && i_valid;
    assign o_stall   = (r_state != chl1_pkg::S_IDLE);
    assign slot_free = !o_valid || !i_stall;
    assign e_last    = (r_e == EIW'(NE - 1));
    assign skip_e    = (r_b == 8'd0) && !r_pres[r_e];
    assign emit_done = (r_state == chl1_pkg::S_EMIT) && slot_free && (rank_cnt == CNTW'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            chl1_pkg::S_INIT: begin
                if (r_init == AW'(DEPTH - 1)) n_state = chl1_pkg::S_IDLE;
            end
            chl1_pkg::S_IDLE: begin
                if (i_valid) begin
                    case (chl1_pkg::t_kind'(i_kind))
                        chl1_pkg::K_LOAD: begin
                            if (in_open && i_has_char) n_state = chl1_pkg::S_BUMP;
                            else if (i_last)           n_state = chl1_pkg::S_RES;
                        end
                        chl1_pkg::K_QUERY: begin
                            if (i_has_char)  n_state = chl1_pkg::S_BUMP;
                            else if (i_last) n_state = chl1_pkg::S_WALK;
                        end
                        chl1_pkg::K_ERASE: begin
                            n_state = in_inr ? chl1_pkg::S_ERASE : chl1_pkg::S_RES;
                        end
                        default: n_state = chl1_pkg::S_IDLE;
                    endcase
                end
            end
            chl1_pkg::S_BUMP: begin
                if (!r_last)                   n_state = chl1_pkg::S_IDLE;
                else if (r_kind == chl1_pkg::K_LOAD) n_state = chl1_pkg::S_RES;
                else                           n_state = chl1_pkg::S_WALK;
            end
            chl1_pkg::S_ERASE: begin
                if (r_b == 8'hFF) n_state = chl1_pkg::S_RES;
            end
            chl1_pkg::S_RES: begin
                if (slot_free) n_state = chl1_pkg::S_IDLE;
            end
            chl1_pkg::S_WALK: begin
                if (skip_e) begin
                    if (e_last) n_state = chl1_pkg::S_QCLR;
                end else if (r_b == 8'hFF) begin
                    n_state = chl1_pkg::S_DRAIN;
                end
            end
            chl1_pkg::S_DRAIN: n_state = chl1_pkg::S_INS;
            chl1_pkg::S_INS:   n_state = e_last ? chl1_pkg::S_QCLR : chl1_pkg::S_WALK;
            chl1_pkg::S_QCLR: begin
                if (r_b == 8'hFF) begin
                    n_state = (rank_cnt == '0) ? chl1_pkg::S_RES : chl1_pkg::S_EMIT;
                end
            end
            chl1_pkg::S_EMIT: begin
                if (slot_free && rank_cnt == CNTW'(1)) n_state = chl1_pkg::S_IDLE;
            end
            default: n_state = chl1_pkg::S_INIT;
        endcase
    end

    // Datapath controls.
    always_comb begin
        ref_raddr  = AW'({r_e, r_b});
        q_raddr    = r_b;
        ref_we     = 1'b0;
        ref_waddr  = AW'({r_entry[EIW-1:0], r_ch});
        ref_wdata  = '0;
        q_we       = 1'b0;
        q_waddr    = r_ch;
        q_wdata    = '0;
        acc_clr    = 1'b0;
        acc_en     = r_rdv;
        rank_ctl   = '0;
        out_load   = 1'b0;
        out_status = chl1_pkg::ST_RANKED;
        out_idx    = r_ri;
        out_dist   = '0;
        out_fin    = 1'b1;
        set_pres   = 1'b0;
        clr_pres   = 1'b0;
        case (r_state)
            chl1_pkg::S_INIT: begin
                ref_we    = 1'b1;
                ref_waddr = r_init;
                q_we      = 1'b1;
                q_waddr   = r_init[7:0];
            end
            chl1_pkg::S_IDLE: begin
                ref_raddr      = AW'({i_entry[EIW-1:0], in_ch});
                q_raddr        = in_ch;
                acc_clr        = 1'b1;
                rank_ctl.clear = 1'b1;
                set_pres = accept && (i_kind == chl1_pkg::K_LOAD) && i_last && in_open
                           && !i_has_char;
            end
            chl1_pkg::S_BUMP: begin
                if (r_kind == chl1_pkg::K_LOAD) begin
                    ref_we    = 1'b1;
                    ref_wdata = (r_ref_rd == CMAX) ? r_ref_rd : r_ref_rd + 1'b1;
                    set_pres  = r_last;
                end else begin
                    q_we    = 1'b1;
                    q_wdata = (r_q_rd == CMAX) ? r_q_rd : r_q_rd + 1'b1;
                end
            end
            chl1_pkg::S_ERASE: begin
                ref_we    = 1'b1;
                ref_waddr = AW'({r_entry[EIW-1:0], r_b});
                clr_pres  = (r_b == 8'hFF);
            end
            chl1_pkg::S_RES: begin
                out_load   = slot_free;
                out_status = r_rs;
            end
            chl1_pkg::S_INS: begin
                rank_ctl.ins = 1'b1;
                acc_clr      = 1'b1;
            end
            chl1_pkg::S_QCLR: begin
                q_we    = 1'b1;
                q_waddr = r_b;
            end
            chl1_pkg::S_EMIT: begin
                out_load     = slot_free;
                rank_ctl.pop = slot_free;
                out_idx      = head_idx;
                out_dist     = 21'(head_dist);
                out_fin      = (rank_cnt == CNTW'(1));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chl1_pkg::S_INIT;
            r_init  <= '0;
            r_pres  <= '0;
            r_rdv   <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rdv   <= (r_state == chl1_pkg::S_WALK) && !skip_e;
            if (r_state == chl1_pkg::S_INIT) r_init <= r_init + 1'b1;
            if (set_pres) begin
                r_pres[(r_state == chl1_pkg::S_IDLE) ? i_entry[EIW-1:0] : r_entry[EIW-1:0]]
                    <= 1'b1;
            end
            if (clr_pres) r_pres[r_entry[EIW-1:0]] <= 1'b0;
            if (out_load)        o_valid <= 1'b1;
            else if (!i_stall)   o_valid <= 1'b0;
        end
    end

    // Item fields, counters and result staging.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_kind;
            r_entry <= i_entry;
            r_ch    <= in_ch;
            r_last  <= i_last;
            r_e     <= '0;
            r_b     <= '0;
            r_ri    <= i_entry;
            if (i_kind == chl1_pkg::K_LOAD) begin
                r_rs <= in_open ? chl1_pkg::ST_LOAD_OK : chl1_pkg::ST_LOAD_REJ;
            end else begin
                r_rs <= chl1_pkg::ST_ERASE_EMPTY;
            end
        end
        case (r_state)
            chl1_pkg::S_ERASE: begin
                r_b <= r_b + 1'b1;
                if (r_b == 8'hFF && r_pres[r_entry[EIW-1:0]]) r_rs <= chl1_pkg::ST_ERASED;
            end
            chl1_pkg::S_WALK: begin
                if (skip_e) begin
                    if (!e_last) r_e <= r_e + 1'b1;
                end else begin
                    r_b <= r_b + 1'b1;
                end
            end
            chl1_pkg::S_INS: begin
                if (!e_last) r_e <= r_e + 1'b1;
            end
            chl1_pkg::S_QCLR: begin
                r_b  <= r_b + 1'b1;
                r_rs <= chl1_pkg::ST_NO_ENTRIES;
                r_ri <= '0;
            end
            default: ;
        endcase
        if (out_load) begin
            o_status      <= out_status;
            o_entry_index <= out_idx;
            o_distance    <= out_dist;
            o_final_res   <= out_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ref_we) ref_mem[ref_waddr] <= ref_wdata;
        r_ref_rd <= ref_mem[ref_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) q_mem[q_waddr] <= q_wdata;
        r_q_rd <= q_mem[q_raddr];
    end

    chl1_acc #(
        .CW (COUNT_BITS),
        .DW (DW)
    ) u_acc (
        .i_clk (i_clk),
        .i_clr (acc_clr),
        .i_en  (acc_en),
        .i_ref (r_ref_rd),
        .i_qry (r_q_rd),
        .o_sum (acc_sum)
    );

    chl1_rank #(
        .NE   (NE),
        .DW   (DW),
        .CNTW (CNTW)
    ) u_rank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (rank_ctl),
        .i_idx       (4'(r_e)),
        .i_dist      (acc_sum),
        .o_head_idx  (head_idx),
        .o_head_dist (head_dist),
        .o_count     (rank_cnt)
    );

    `CHL1_ASSERT_IMPL(a_init_quiet, r_state == chl1_pkg::S_INIT, !o_valid)
    `CHL1_ASSERT_NEXT(a_emit_done, emit_done, r_state == chl1_pkg::S_IDLE)
    `CHL1_ASSERT_IMPL(a_one_mem_writer, ref_we && q_we, r_state == chl1_pkg::S_INIT)

endmodule

>>> tb/char_histogram_l1_ranker_tb.sv
// Self-checking testbench for the character histogram L1 ranker.
`timescale 1ns / 1ps

module char_histogram_l1_ranker_tb;

    localparam int NUM_ENTRIES = 16;
    localparam int COUNT_TOP   = 4095;
    localparam int IDLE_LIMIT  = 40000;
    localparam int RANDOM_ITEMS = 300;

    typedef struct packed {
        chl1_pkg::t_status status;
        logic [3:0]  entry_index;
        logic [20:0] distance;
        logic        final_res;
    } t_ranked;

    typedef struct {
        chl1_pkg::t_kind   kind;
        logic [3:0]        entry;
        logic [7:0]        char_byte;
        logic              has_char;
        logic              last;
        logic              typed;
        chl1_pkg::t_status exp_status;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_kind = '0;
    logic [3:0]  i_entry = '0;
    logic [7:0]  i_char_byte = '0;
    logic        i_has_char = 1'b0;
    logic        i_last = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [3:0]  o_entry_index;
    logic [20:0] o_distance;
    logic        o_final_res;

    logic [11:0] ref_hist [NUM_ENTRIES][256];
    logic        entry_live [NUM_ENTRIES];
    logic [11:0] query_hist [256];
    t_ranked     pending_results [$];

    int  sender_idle_pct = 0;
    int  receiver_stall_pct = 0;
    int  quiet_cycles = 0;
    bit  failed = 1'b0;

    char_histogram_l1_ranker uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(i_kind), .i_entry(i_entry), .i_char_byte(i_char_byte),
        .i_has_char(i_has_char), .i_last(i_last), .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_entry_index(o_entry_index), .o_distance(o_distance),
        .o_final_res(o_final_res)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [7:0] lower_case(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
    endfunction

    // Appends one result to the end of a result queue.
    function automatic void append_result(ref t_ranked q[$], input t_ranked item);
        q = {q, item};
    endfunction

    // Updates the histograms for one beat and returns the results it causes.
    function automatic void rank_step(input chl1_pkg::t_kind kind, input logic [3:0] entry,
                                      input logic [7:0] char_byte, input logic has_char,
                                      input logic last, ref t_ranked res[$]);
        logic [7:0]  bin;
        logic [20:0] ent_dist [NUM_ENTRIES];
        int          order [NUM_ENTRIES];
        int          n;
        int          j;
        bin = lower_case(char_byte);
        res.delete();
        n = 0;
        case (kind)
            chl1_pkg::K_LOAD: begin
                if (!entry_live[entry] && has_char && ref_hist[entry][bin] != COUNT_TOP) begin
                    ref_hist[entry][bin] += 1;
                end
                if (last) begin
                    append_result(res, {entry_live[entry] ? chl1_pkg::ST_LOAD_REJ :
                                        chl1_pkg::ST_LOAD_OK, entry, 21'd0, 1'b1});
                    entry_live[entry] = 1'b1;
                end
            end
            chl1_pkg::K_ERASE: begin
                append_result(res, {entry_live[entry] ? chl1_pkg::ST_ERASED :
                                    chl1_pkg::ST_ERASE_EMPTY, entry, 21'd0, 1'b1});
                entry_live[entry] = 1'b0;
                for (int b = 0; b < 256; b++) ref_hist[entry][b] = '0;
            end
            chl1_pkg::K_QUERY: begin
                if (has_char && query_hist[bin] != COUNT_TOP) query_hist[bin] += 1;
                if (last) begin
                    for (int e = 0; e < NUM_ENTRIES; e++) begin
                        if (!entry_live[e]) continue;
                        ent_dist[e] = '0;
                        for (int b = 0; b < 256; b++) begin
                            ent_dist[e] += (ref_hist[e][b] > query_hist[b]) ?
                                           ref_hist[e][b] - query_hist[b] :
                                           query_hist[b] - ref_hist[e][b];
                        end
                        // Equal distances keep the lower index first.
                        j = n;
                        while (j > 0 && ent_dist[order[j-1]] > ent_dist[e]) begin
                            order[j] = order[j-1];
                            j--;
                        end
                        order[j] = e;
                        n++;
                    end
                    for (int b = 0; b < 256; b++) query_hist[b] = '0;
                    if (n == 0) begin
                        append_result(res, {chl1_pkg::ST_NO_ENTRIES, 4'd0, 21'd0, 1'b1});
                    end
                    for (int i = 0; i < n; i++) begin
                        append_result(res, {chl1_pkg::ST_RANKED, 4'(order[i]),
                                            ent_dist[order[i]], 1'(i == n - 1)});
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Drives one beat, records its results, and returns once it is accepted.
    task automatic send_beat(input chl1_pkg::t_kind kind, input logic [3:0] entry,
                             input logic [7:0] char_byte, input logic has_char,
                             input logic last, input logic typed,
                             input chl1_pkg::t_status exp_st);
        t_ranked res[$];
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_kind = kind;
        i_entry = entry;
        i_char_byte = char_byte;
        i_has_char = has_char;
        i_last = last;
        do @(posedge i_clk); while (o_stall);
        rank_step(kind, entry, char_byte, has_char, last, res);
        if (typed) begin
            append_result(pending_results, {exp_st, entry, 21'd0, 1'b1});
        end else begin
            foreach (res[k]) append_result(pending_results, res[k]);
        end
        @(negedge i_clk);
    endtask

    task automatic random_char(output logic [7:0] c);
        case ($urandom_range(3))
            0: c = 8'h41 + 8'($urandom_range(25));
            1: c = 8'h61 + 8'($urandom_range(25));
            2: c = 8'($urandom_range(255));
            default: c = 8'h61 + 8'($urandom_range(3));
        endcase
    endtask

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: status %0d entry %0d", o_status,
                       o_entry_index);
                failed = 1'b1;
            end else begin
                t_ranked want;
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    failed = 1'b1;
                end
                if (o_entry_index !== want.entry_index) begin
                    $error("entry_index: expected %0d, got %0d", want.entry_index,
                           o_entry_index);
                    failed = 1'b1;
                end
                if (o_distance !== want.distance) begin
                    $error("distance: expected %0d, got %0d", want.distance, o_distance);
                    failed = 1'b1;
                end
                if (o_final_res !== want.final_res) begin
                    $error("final_res: expected %0d, got %0d", want.final_res, o_final_res);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: counts cycles with no beat moving on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    t_stim_row directed [] = '{
        '{chl1_pkg::K_QUERY, 4'd0,  8'h00, 1'b0, 1'b1, 1'b1, chl1_pkg::ST_NO_ENTRIES},
        '{chl1_pkg::K_ERASE, 4'd3,  8'h00, 1'b0, 1'b0, 1'b1, chl1_pkg::ST_ERASE_EMPTY},
        '{chl1_pkg::K_LOAD,  4'd0,  8'h41, 1'b1, 1'b0, 1'b0, chl1_pkg::ST_RANKED},
        '{chl1_pkg::K_LOAD,  4'd0,  8'hFF, 1'b1, 1'b1, 1'b1, chl1_pkg::ST_LOAD_OK},
        '{chl1_pkg::K_LOAD,  4'd0,  8'h61, 1'b1, 1'b1, 1'b1, chl1_pkg::ST_LOAD_REJ},
        '{chl1_pkg::K_LOAD,  4'd1,  8'h5A, 1'b0, 1'b1, 1'b1, chl1_pkg::ST_LOAD_OK},
        '{chl1_pkg::K_LOAD,  4'd15, 8'h00, 1'b1, 1'b1, 1'b1, chl1_pkg::ST_LOAD_OK},
        '{chl1_pkg::K_LOAD,  4'd2,  8'h5A, 1'b1, 1'b0, 1'b0, chl1_pkg::ST_RANKED},
        '{chl1_pkg::K_LOAD,  4'd2,  8'h7A, 1'b1, 1'b1, 1'b1, chl1_pkg::ST_LOAD_OK},
        '{chl1_pkg::K_QUERY, 4'd9,  8'h61, 1'b1, 1'b0, 1'b0, chl1_pkg::ST_RANKED},
        '{chl1_pkg::K_QUERY, 4'd6,  8'h5A, 1'b1, 1'b0, 1'b0, chl1_pkg::ST_RANKED},
        '{chl1_pkg::K_QUERY, 4'd0,  8'h40, 1'b1, 1'b1, 1'b0, chl1_pkg::ST_RANKED},
        '{chl1_pkg::K_NONE,  4'd5,  8'h41, 1'b1, 1'b1, 1'b0, chl1_pkg::ST_RANKED},
        '{chl1_pkg::K_ERASE, 4'd1,  8'h00, 1'b0, 1'b1, 1'b1, chl1_pkg::ST_ERASED},
        '{chl1_pkg::K_QUERY, 4'd15, 8'h00, 1'b0, 1'b1, 1'b0, chl1_pkg::ST_RANKED},
        '{chl1_pkg::K_ERASE, 4'd2,  8'h00, 1'b0, 1'b0, 1'b1, chl1_pkg::ST_ERASED},
        '{chl1_pkg::K_LOAD,  4'd2,  8'h80, 1'b1, 1'b1, 1'b1, chl1_pkg::ST_LOAD_OK},
        '{chl1_pkg::K_QUERY, 4'd0,  8'h5B, 1'b1, 1'b1, 1'b0, chl1_pkg::ST_RANKED}
    };

    initial begin
        logic [7:0] c;
        logic [3:0] e;
        int sent;
        int len;
        int op;
        foreach (entry_live[k]) entry_live[k] = 1'b0;
        foreach (query_hist[b]) query_hist[b] = '0;
        foreach (ref_hist[k, b]) ref_hist[k][b] = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[r]) begin
            send_beat(directed[r].kind, directed[r].entry, directed[r].char_byte,
                      directed[r].has_char, directed[r].last, directed[r].typed,
                      directed[r].exp_status);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ((sent * 4) / RANDOM_ITEMS)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 74; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 74; end
                default: begin sender_idle_pct = 26; receiver_stall_pct = 26; end
            endcase
            op = $urandom_range(99);
            e = 4'($urandom_range(15));
            len = $urandom_range(5);
            if (op < 40) begin
                // Reference string; length zero is the empty string.
                for (int n = 0; n <= len; n++) begin
                    random_char(c);
                    send_beat(chl1_pkg::K_LOAD, e, c, len != 0, n == len, 1'b0,
                              chl1_pkg::ST_RANKED);
                    sent++;
                end
            end else if (op < 62) begin
                for (int n = 0; n <= len; n++) begin
                    random_char(c);
                    send_beat(chl1_pkg::K_QUERY, 4'($urandom_range(15)), c, len != 0,
                              n == len, 1'b0, chl1_pkg::ST_RANKED);
                    sent++;
                end
            end else if (op < 80) begin
                send_beat(chl1_pkg::K_ERASE, e, 8'($urandom_range(255)),
                          1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0,
                          chl1_pkg::ST_RANKED);
                sent++;
            end else if (op < 90) begin
                // Broken load: characters with no closing beat.
                for (int n = 0; n <= len; n++) begin
                    random_char(c);
                    send_beat(chl1_pkg::K_LOAD, e, c, 1'b1, 1'b0, 1'b0, chl1_pkg::ST_RANKED);
                    sent++;
                end
            end else begin
                send_beat(chl1_pkg::t_kind'($urandom_range(3)), e, 8'($urandom_range(255)),
                          1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0,
                          chl1_pkg::ST_RANKED);
                sent++;
            end
        end
        i_valid = 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (!failed) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
